>>> rtl/gmle_pkg.sv
// package for the generator matrix ldpc encoder
// shared types, register indexes, reset values and parameter defaults
// depends on nothing
package gmle_pkg;

    localparam int MSG_MAX_DEF   = 512;
    localparam int CW_MAX_DEF    = 1024;
    localparam int WORD_BITS_DEF = 64;

    localparam int MSG_LEN_W = 10;
    localparam int CW_LEN_W  = 11;
    localparam int CFG_W     = 11;

    localparam logic [MSG_LEN_W-1:0] MSG_LEN_RST = 10'd512;
    localparam logic [CW_LEN_W-1:0]  CW_LEN_RST  = 11'd1024;

    typedef enum logic {
        REG_MSG_LEN = 1'b0,
        REG_CW_LEN  = 1'b1
    } reg_idx_t;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_MSG  = 1'b1
    } cmd_t;

    typedef struct packed {
        logic        cmd;
        logic [8:0]  row_index;
        logic [3:0]  word_index;
        logic [63:0] load_word;
        logic        message_bit;
    } item_t;

    typedef struct packed {
        logic [63:0] codeword_word;
        logic [6:0]  bits_valid;
        logic        last;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_XOR,
        ST_DIV,
        ST_PRIME,
        ST_FILL,
        ST_EMIT
    } state_t;

endpackage

>>> rtl/gmle_ram.sv
// generic simple dual port ram, one write port and one registered read port
// depends on nothing
module gmle_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/gmle_div.sv
// constant divider for the codeword column split, by reciprocal multiply
// quotient is registered on start, remainder comes from the registered quotient
// depends on nothing
module gmle_div #(
    parameter int DV_W    = 11,
    parameter int Q_W     = 5,
    parameter int R_W     = 6,
    parameter int DIVISOR = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [DV_W-1:0] dividend,
    output logic            done,
    output logic [Q_W-1:0]  quot,
    output logic [R_W-1:0]  rem
);

    localparam int L_SH = (DIVISOR > 1) ? $clog2(DIVISOR) : 0;
    localparam int S_SH = DV_W + L_SH;
    localparam int P_W  = 2 * DV_W + 1;
    localparam longint unsigned RECIP =
        ((64'd1 << S_SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

    logic [P_W-1:0]  prod;
    logic [DV_W-1:0] back;
    logic [DV_W-1:0] dvd_reg;
    logic [Q_W-1:0]  quot_reg;
    logic            done_reg;

    // rounded-up reciprocal is exact for every dividend below 2**DV_W
    assign prod = P_W'(dividend) * P_W'(RECIP);
    assign back = DV_W'(32'(quot_reg) * DIVISOR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg  <= dividend;
            quot_reg <= Q_W'(prod >> S_SH);
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = R_W'(dvd_reg - back);

endmodule

>>> rtl/generator_matrix_ldpc_encoder_unit.sv
// generator matrix ldpc encoder: load items never make it busy, nor does a message bit of zero
// other than the final bit; an in-range bit of one holds busy, one accumulator word per
// cycle through the read-modify-write of the accumulator ram against the generator ram port.
// the final bit then runs the column split, then one word per cycle, strobed the cycle after
// its emit cycle; the receiver cannot stall. async active-low reset loads the length defaults,
// clears state, bit counter and acc valid bits; the generator ram holds garbage until loaded
module generator_matrix_ldpc_encoder_unit #(
    parameter int MSG_MAX   = gmle_pkg::MSG_MAX_DEF,
    parameter int CW_MAX    = gmle_pkg::CW_MAX_DEF,
    parameter int WORD_BITS = gmle_pkg::WORD_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  gmle_pkg::item_t            item,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [gmle_pkg::CFG_W-1:0] cfg_data,
    output logic                       strobe,
    output gmle_pkg::result_t          result
);

    import gmle_pkg::*;

    localparam int ROW_WORDS = CW_MAX / WORD_BITS;
    localparam int GEN_DEPTH = MSG_MAX * ROW_WORDS;
    localparam int GA_W      = (GEN_DEPTH > 1) ? $clog2(GEN_DEPTH) : 1;
    localparam int AI_W      = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
    localparam int XW_W      = $clog2(ROW_WORDS + 1);
    localparam int RB_W      = $clog2(WORD_BITS);
    localparam int ML_W      = $clog2(MSG_MAX + 1);
    localparam int MLX_W     = (ML_W > MSG_LEN_W) ? ML_W : MSG_LEN_W;
    localparam int CWL_W     = $clog2(CW_MAX + 1);
    localparam int CWX_W     = (CWL_W > CW_LEN_W) ? CWL_W : CW_LEN_W;

    state_t state_reg, state_next;

    logic [MSG_LEN_W-1:0] msg_len_reg;
    logic [CW_LEN_W-1:0]  cw_len_reg;
    logic [MSG_LEN_W-1:0] br_reg;
    logic [ROW_WORDS-1:0] acc_vld_reg;
    logic [XW_W-1:0]      xw_reg;
    logic                 end_reg;
    logic                 acc_ok_reg;
    logic                 strobe_reg;
    logic                 lo_zero_reg;

    logic [GA_W-1:0]      gen_base_reg;
    logic [XW_W-1:0]      ptr_reg;
    logic [CWX_W-1:0]     vrem_reg;
    logic [WORD_BITS-1:0] hi_reg;
    result_t              result_reg, result_next;

    logic                 accept;
    logic [MLX_W-1:0]     ml_raw, ml_eff, pos;
    logic [MLX_W:0]       k_ext, k1_ext, ml_ext;
    logic                 bit_in_range, msg_end;
    logic [CWX_W-1:0]     cw_raw, cw_eff;

    logic                 gen_we, ld_ok;
    logic [GA_W-1:0]      gen_waddr, gen_raddr, gen_base;
    logic [WORD_BITS-1:0] gen_q;

    logic                 acc_we;
    logic [AI_W-1:0]      acc_waddr, acc_raddr;
    logic [XW_W-1:0]      acc_ridx;
    logic [WORD_BITS-1:0] acc_q, acc_word, acc_wdata;

    logic                 div_start, div_done;
    logic [XW_W-1:0]      div_q;
    logic [RB_W-1:0]      div_r;

    logic                   emit_last;
    logic [WORD_BITS-1:0]   lo_word, win, rev;
    logic [2*WORD_BITS-1:0] cat, cat_sh;
    logic [RB_W:0]          shamt;
    logic [6:0]             bv;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    // effective lengths with out-of-range register values clamped
    assign ml_raw = MLX_W'(msg_len_reg);
    assign cw_raw = CWX_W'(cw_len_reg);

    always_comb
    begin
        if (ml_raw == '0)
            ml_eff = MLX_W'(1);
        else if (ml_raw > MLX_W'(MSG_MAX))
            ml_eff = MLX_W'(MSG_MAX);
        else
            ml_eff = ml_raw;
        if (cw_raw == '0)
            cw_eff = CWX_W'(1);
        else if (cw_raw > CWX_W'(CW_MAX))
            cw_eff = CWX_W'(CW_MAX);
        else
            cw_eff = cw_raw;
    end

    assign k_ext        = (MLX_W+1)'(br_reg);
    assign k1_ext       = k_ext + (MLX_W+1)'(1);
    assign ml_ext       = {1'b0, ml_eff};
    assign bit_in_range = (k_ext < ml_ext);
    assign msg_end      = (k1_ext >= ml_ext);
    assign pos          = ml_eff - MLX_W'(1) - k_ext[MLX_W-1:0];
    assign gen_base     = GA_W'(32'(pos) * ROW_WORDS);

    // generator store
    assign ld_ok     = (32'(item.row_index) < MSG_MAX) && (32'(item.word_index) < ROW_WORDS);
    assign gen_we    = accept && (item.cmd == CMD_LOAD) && ld_ok;
    assign gen_waddr = GA_W'(32'(item.row_index) * ROW_WORDS + 32'(item.word_index));
    assign gen_raddr = gen_base_reg + GA_W'(xw_reg);

    gmle_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (GEN_DEPTH)
    ) u_gen_ram (
        .clk   (clk),
        .we    (gen_we),
        .waddr (gen_waddr),
        .wdata (item.load_word[WORD_BITS-1:0]),
        .raddr (gen_raddr),
        .rdata (gen_q)
    );

    // parity accumulator, entries without a valid bit read as zero
    assign acc_raddr = acc_ridx[AI_W-1:0];
    assign acc_word  = acc_ok_reg ? acc_q : '0;
    assign acc_wdata = acc_word ^ gen_q;

    gmle_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (ROW_WORDS)
    ) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .raddr (acc_raddr),
        .rdata (acc_q)
    );

    gmle_div #(
        .DV_W    (CWX_W),
        .Q_W     (XW_W),
        .R_W     (RB_W),
        .DIVISOR (WORD_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cw_eff - CWX_W'(1)),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    // codeword word: window of two accumulator words, bit order reversed
    assign lo_word = lo_zero_reg ? '0 : acc_word;
    assign cat     = {hi_reg, lo_word};
    assign shamt   = (RB_W+1)'(div_r) + (RB_W+1)'(1);
    assign cat_sh  = cat >> shamt;
    assign win     = cat_sh[WORD_BITS-1:0];

    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            rev[i] = win[WORD_BITS-1-i];
        end
    end

    assign bv = (vrem_reg > CWX_W'(WORD_BITS)) ? 7'(WORD_BITS) : 7'(vrem_reg);

    always_comb
    begin
        result_next.codeword_word = 64'(rev);
        result_next.bits_valid    = bv;
        result_next.last          = emit_last;
    end

    always_comb
    begin
        state_next = state_reg;
        acc_ridx   = '0;
        acc_we     = 1'b0;
        acc_waddr  = '0;
        emit_last  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (item.cmd == CMD_MSG))
                begin
                    if (item.message_bit && bit_in_range)
                        state_next = ST_XOR;
                    else if (msg_end)
                        state_next = ST_DIV;
                end
            end
            ST_XOR:
            begin
                // read word xw while writing back word xw-1
                acc_ridx = xw_reg;
                if (xw_reg != '0)
                begin
                    acc_we    = 1'b1;
                    acc_waddr = AI_W'(xw_reg - XW_W'(1));
                end
                if (xw_reg == XW_W'(ROW_WORDS))
                    state_next = end_reg ? ST_DIV : ST_IDLE;
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_PRIME;
            end
            ST_PRIME:
            begin
                acc_ridx   = div_q;
                state_next = ST_FILL;
            end
            ST_FILL:
            begin
                acc_ridx   = div_q - XW_W'(1);
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                emit_last = (vrem_reg <= CWX_W'(WORD_BITS));
                acc_ridx  = ptr_reg - XW_W'(1);
                if (emit_last)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign div_start = (state_next == ST_DIV) && (state_reg != ST_DIV);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_len_reg <= MSG_LEN_RST;
            cw_len_reg  <= CW_LEN_RST;
            br_reg      <= '0;
            acc_vld_reg <= '0;
            xw_reg      <= '0;
            end_reg     <= 1'b0;
            acc_ok_reg  <= 1'b0;
            strobe_reg  <= 1'b0;
            lo_zero_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MSG_LEN: msg_len_reg <= cfg_data[MSG_LEN_W-1:0];
                    REG_CW_LEN:  cw_len_reg  <= cfg_data[CW_LEN_W-1:0];
                    default:     cw_len_reg  <= cw_len_reg;
                endcase
            end
            acc_ok_reg <= (32'(acc_ridx) < ROW_WORDS) && acc_vld_reg[acc_raddr];
            strobe_reg <= (state_reg == ST_EMIT);
            if (acc_we)
                acc_vld_reg[acc_waddr] <= 1'b1;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (item.cmd == CMD_MSG))
                    begin
                        br_reg  <= msg_end ? '0 : k1_ext[MSG_LEN_W-1:0];
                        end_reg <= msg_end;
                        xw_reg  <= '0;
                    end
                end
                ST_XOR:
                begin
                    xw_reg <= xw_reg + XW_W'(1);
                end
                ST_FILL:
                begin
                    lo_zero_reg <= (div_q == '0);
                end
                ST_EMIT:
                begin
                    lo_zero_reg <= lo_zero_reg || (ptr_reg == '0);
                    if (emit_last)
                        acc_vld_reg <= '0;
                end
                default:
                begin
                    end_reg <= end_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (item.cmd == CMD_MSG))
            gen_base_reg <= gen_base;
        if (state_reg == ST_PRIME)
            vrem_reg <= cw_eff;
        if (state_reg == ST_FILL)
        begin
            hi_reg  <= acc_word;
            ptr_reg <= div_q - XW_W'(1);
        end
        if (state_reg == ST_EMIT)
        begin
            hi_reg     <= lo_word;
            ptr_reg    <= ptr_reg - XW_W'(1);
            vrem_reg   <= vrem_reg - CWX_W'(WORD_BITS);
            result_reg <= result_next;
        end
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

    // no word follows the last word of a codeword
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.last) |=> !strobe)
        else $error("result transfer after last word");

    // read-modify-write never reads the entry being written back
    assert property (@(posedge clk) disable iff (!rst_n)
        (acc_we && (xw_reg != XW_W'(ROW_WORDS))) |-> (acc_waddr != acc_raddr))
        else $error("accumulator read and write collide");

    // accumulator and bit counter are clear once a codeword is out
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && emit_last) |=> (acc_vld_reg == '0 && br_reg == '0))
        else $error("accumulator not cleared after codeword");

    // generator loads only land while no message work is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        gen_we |-> (state_reg == ST_IDLE))
        else $error("generator write while busy");

    // column split finished within one word
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && div_done) |-> (32'(div_r) < WORD_BITS))
        else $error("column offset out of range");

endmodule
